// ----- rtl/core/tkwsc_pkg.sv -----
// Package for the table-keyed word stream cipher.
// Holds word types, operation codes, cipher constants and the elaboration-time mixing table.
`timescale 1ns / 1ps

package tkwsc_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned TableIdxW  = $clog2(TableDepth);
  localparam int unsigned EntriesRow = 5;

  typedef logic [WordWidth-1:0] word_t;
  typedef word_t [TableDepth-1:0] mix_table_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam word_t SEED_INIT = 32'hEEEE_EEEE;
  localparam word_t KEY_ADD   = 32'h1111_1111;
  localparam int unsigned KEY_SHL = 21;
  localparam int unsigned KEY_SHR = 11;
  localparam int unsigned SEED_SHL = 5;
  localparam word_t SEED_ADD  = 32'd3;

  localparam word_t LCG_START = 32'h0010_0001;
  localparam word_t LCG_MUL   = 32'd125;
  localparam word_t LCG_INC   = 32'd3;
  localparam word_t LCG_MOD   = 32'h002A_AAAB;

  // State stays below LCG_MOD, so the product never wraps 32 bits.
  function automatic word_t lcg_next(input word_t s);
    return (s * LCG_MUL + LCG_INC) % LCG_MOD;
  endfunction

  // Fifth entry of each row of the generator sequence; evaluated at elaboration.
  function automatic mix_table_t build_mix_table();
    mix_table_t tbl;
    word_t      s;
    word_t      hi;
    tbl = '0;
    s   = LCG_START;
    for (int r = 0; r < TableDepth; r++) begin
      for (int k = 0; k < EntriesRow; k++) begin
        s  = lcg_next(s);
        hi = s;
        s  = lcg_next(s);
        if (k == EntriesRow - 1) begin
          tbl[r] = {hi[15:0], s[15:0]};
        end
      end
    end
    return tbl;
  endfunction

  localparam mix_table_t MIX_TABLE = build_mix_table();

  function automatic word_t key_rotate(input word_t key);
    return ((~key) << KEY_SHL) + KEY_ADD | (key >> KEY_SHR);
  endfunction

endpackage

// ----- rtl/core/table_keyed_word_stream_cipher.sv -----
// Top level of the table-keyed word stream cipher: input register, key/seed
// update with table lookup, output register. Depends on tkwsc_pkg.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o   | operation_i start_block_i block_key_i data_in_i
//  out     | out_valid_o / out_stall_i | data_out_o
//
// One word per cycle sustained while the output does not stall.
// The key and seed registers update in the same cycle a word leaves the input
// register, so the next word sees them at once.
// Reset clears both valid flags, key to zero and seed to 0xEEEEEEEE.
// A stalled output holds its word; the input register stalls only when full
// and the output register is full and stalled.
`timescale 1ns / 1ps

module table_keyed_word_stream_cipher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic                 start_block_i,
  input  tkwsc_pkg::word_t     block_key_i,
  input  tkwsc_pkg::word_t     data_in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tkwsc_pkg::word_t     data_out_o
);
  import tkwsc_pkg::*;

  logic  s1_valid_q;
  logic  s1_op_q;
  logic  s1_start_q;
  word_t s1_key_q;
  word_t s1_data_q;

  logic  out_valid_q;
  word_t out_data_q;

  word_t key_q, key_d;
  word_t seed_q, seed_d;

  logic  advance;
  logic  in_accept;
  word_t key_use;
  word_t seed_base;
  word_t seed_mix;
  word_t result;
  word_t plain;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    key_use   = s1_start_q ? s1_key_q : key_q;
    seed_base = s1_start_q ? SEED_INIT : seed_q;
    seed_mix  = seed_base + MIX_TABLE[key_use[TableIdxW-1:0]];
    result    = s1_data_q ^ (key_use + seed_mix);
    plain     = (s1_op_q == OP_DECRYPT) ? result : s1_data_q;
    key_d     = key_rotate(key_use);
    seed_d    = plain + seed_mix + (seed_mix << SEED_SHL) + SEED_ADD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_q       <= '0;
      seed_q      <= SEED_INIT;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        key_q       <= key_d;
        seed_q      <= seed_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q    <= operation_i;
      s1_start_q <= start_block_i;
      s1_key_q   <= block_key_i;
      s1_data_q  <= data_in_i;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full, stalled pipeline");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("output register not filled after advance");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(key_q) && $stable(seed_q)))
    else $error("key or seed changed without a word moving");

  a_out_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !advance) |=> !out_valid_q)
    else $error("taken word not cleared from output register");

endmodule
